### rtl/core/assert_macros.svh
// Assertion macros used by the checker file prt_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, ignored while reset is asserted.
`define PRT_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication checked on every rising edge, ignored while reset is asserted.
`define PRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/core/prt_pkg.sv
// Types, codes and helpers for the prescaled reload down timer.
// No dependencies; used by every module of the block.
package prt_pkg;

    localparam int DATA_W = 16;
    localparam int CNT_W  = 15;
    localparam int CTRL_W = 8;
    localparam int PS_W   = 7;

    // operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // register select codes
    localparam logic [1:0] SEL_RELOAD  = 2'd0;
    localparam logic [1:0] SEL_COUNT   = 2'd1;
    localparam logic [1:0] SEL_CONTROL = 2'd2;

    // prescaler mode codes, control bits 6:5
    localparam logic [1:0] PS_DIV1  = 2'd0;
    localparam logic [1:0] PS_DIV16 = 2'd1;
    localparam logic [1:0] PS_DIV4  = 2'd2;
    localparam logic [1:0] PS_DIV64 = 2'd3;

    localparam int CTRL_STOP_BIT  = 0;
    localparam int CTRL_READY_BIT = 7;
    localparam int CTRL_MODE_LSB  = 5;

    typedef struct packed {
        logic [1:0]        operation;
        logic [1:0]        reg_select;
        logic [DATA_W-1:0] write_data;
    } prt_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              ready_flag;
    } prt_rsp_t;

    typedef struct packed {
        logic [CNT_W-1:0]  count_value;
        logic [CNT_W-1:0]  reload_value;
        logic [CTRL_W-1:0] control_bits;
        logic [PS_W-1:0]   prescale_count;
    } prt_state_t;

    function automatic logic [PS_W-1:0] prescale_divisor(input logic [1:0] mode);
        logic [PS_W-1:0] div;
        case (mode)
            PS_DIV16: div = PS_W'(16);
            PS_DIV4:  div = PS_W'(4);
            PS_DIV64: div = PS_W'(64);
            default:  div = PS_W'(1);
        endcase
        return div;
    endfunction

endpackage

### rtl/core/prescaled_reload_down_timer.sv
// Prescaled reload down timer: ticks and register reads/writes, one word each.
// An accepted word waits in the request stage; its result is registered in the result stage once that stage is free.
// Throughput: one word per cycle while req_stall is low; req_stall rises only while a result waits on rsp_stall.
// Reset (rst_n low, asynchronous) empties both stages and zeroes counter, reload,
// control and prescaler.
// Depends on prt_pkg and prt_step.
module prescaled_reload_down_timer
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  prt_pkg::prt_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output prt_pkg::prt_rsp_t rsp
);

    logic                req_valid_reg;
    prt_pkg::prt_req_t   req_word_reg;
    logic                rsp_valid_reg;
    prt_pkg::prt_rsp_t   rsp_word_reg;
    prt_pkg::prt_state_t state_reg;
    prt_pkg::prt_state_t state_next;
    prt_pkg::prt_rsp_t   rsp_next;
    logic                rsp_load;
    logic                req_load;

    // result stage frees when empty or being taken
    assign rsp_load  = !rsp_valid_reg || !rsp_stall;
    assign req_load  = !req_valid_reg || rsp_load;
    assign req_stall = !req_load;

    prt_step u_step
    (
        .state      (state_reg),
        .req        (req_word_reg),
        .state_next (state_next),
        .rsp        (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (req_load)
            begin
                req_valid_reg <= req_valid;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= req_valid_reg;
                if (req_valid_reg)
                begin
                    state_reg <= state_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_load && req_valid)
        begin
            req_word_reg <= req;
        end
        if (rsp_load && req_valid_reg)
        begin
            rsp_word_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_word_reg;

endmodule

### rtl/core/prt_step.sv
// Next-state and response logic for one timer word.
// Depends on prt_pkg.
module prt_step
(
    input  prt_pkg::prt_state_t state,
    input  prt_pkg::prt_req_t   req,
    output prt_pkg::prt_state_t state_next,
    output prt_pkg::prt_rsp_t   rsp
);

    logic [prt_pkg::PS_W-1:0]   ps_inc;
    logic [prt_pkg::PS_W-1:0]   ps_div;
    logic [prt_pkg::CNT_W-1:0]  cnt_dec;
    logic [prt_pkg::DATA_W-1:0] rdata;
    logic                       stopped;

    assign stopped = state.control_bits[prt_pkg::CTRL_STOP_BIT];
    assign ps_inc  = state.prescale_count + prt_pkg::PS_W'(1);
    assign ps_div  = prt_pkg::prescale_divisor(
                         state.control_bits[prt_pkg::CTRL_MODE_LSB +: 2]);
    assign cnt_dec = state.count_value - prt_pkg::CNT_W'(1);

    always_comb
    begin
        state_next = state;
        rdata      = '0;
        case (req.operation)
            prt_pkg::OP_TICK:
            begin
                if (!stopped)
                begin
                    if (ps_inc >= ps_div)
                    begin
                        state_next.prescale_count = '0;
                        // only a decrement that lands on zero expires
                        if (cnt_dec == '0)
                        begin
                            state_next.control_bits[prt_pkg::CTRL_READY_BIT] = 1'b1;
                            state_next.count_value = state.reload_value;
                        end
                        else
                        begin
                            state_next.count_value = cnt_dec;
                        end
                    end
                    else
                    begin
                        state_next.prescale_count = ps_inc;
                    end
                end
            end
            prt_pkg::OP_READ:
            begin
                case (req.reg_select)
                    prt_pkg::SEL_RELOAD:
                    begin
                        rdata = prt_pkg::DATA_W'(state.reload_value);
                    end
                    prt_pkg::SEL_COUNT:
                    begin
                        rdata = prt_pkg::DATA_W'(state.count_value);
                        state_next.control_bits[prt_pkg::CTRL_READY_BIT] = 1'b0;
                    end
                    prt_pkg::SEL_CONTROL:
                    begin
                        rdata = prt_pkg::DATA_W'(state.control_bits);
                    end
                    default:
                    begin
                        rdata = '0;
                    end
                endcase
            end
            prt_pkg::OP_WRITE:
            begin
                case (req.reg_select)
                    prt_pkg::SEL_RELOAD:
                    begin
                        state_next.reload_value = req.write_data[prt_pkg::CNT_W-1:0];
                        if (!stopped)
                        begin
                            state_next.count_value = req.write_data[prt_pkg::CNT_W-1:0];
                        end
                    end
                    prt_pkg::SEL_CONTROL:
                    begin
                        // stopping a running timer loads the counter
                        if (req.write_data[prt_pkg::CTRL_STOP_BIT] && !stopped)
                        begin
                            state_next.count_value = state.reload_value;
                        end
                        state_next.control_bits = req.write_data[prt_pkg::CTRL_W-1:0];
                    end
                    default:
                    begin
                        state_next = state;
                    end
                endcase
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

    assign rsp.read_data  = rdata;
    assign rsp.ready_flag = state_next.control_bits[prt_pkg::CTRL_READY_BIT];

endmodule

### rtl/core/prt_checker.sv
// Port-level checks for the prescaled reload down timer, bound to the top level.
// Depends on prt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module prt_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input prt_pkg::prt_req_t req,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input prt_pkg::prt_rsp_t rsp
);

    `PRT_ASSERT_IMP(a_rsp_valid_held, clk, rst_n, rsp_valid && rsp_stall, ##1 rsp_valid, "rsp_valid dropped while stalled")
    `PRT_ASSERT_IMP(a_rsp_word_held, clk, rst_n, rsp_valid && rsp_stall, ##1 $stable(rsp), "rsp word changed while stalled")
    `PRT_ASSERT_IMP(a_stall_only_back, clk, rst_n, req_stall, rsp_valid && rsp_stall, "req_stall without a blocked result")
    `PRT_ASSERT_IMP(a_word_reaches_rsp, clk, rst_n, req_valid && !req_stall, ##2 rsp_valid, "accepted word did not reach the result stage")

endmodule

bind prescaled_reload_down_timer prt_checker u_prt_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
